@@ sv/csrrf_pkg.sv @@
// ----------------------------------------------------------------------------
// csrrf_pkg
// Types and constants shared by the machine CSR file modules.
// ----------------------------------------------------------------------------
package csrrf_pkg;

    localparam int XLEN = 32;

    // funct3 command codes
    localparam logic [2:0] CMD_ILL0 = 3'd0;
    localparam logic [2:0] CMD_RW   = 3'd1;
    localparam logic [2:0] CMD_RS   = 3'd2;
    localparam logic [2:0] CMD_RC   = 3'd3;
    localparam logic [2:0] CMD_ILL4 = 3'd4;
    localparam logic [2:0] CMD_RWI  = 3'd5;
    localparam logic [2:0] CMD_RSI  = 3'd6;
    localparam logic [2:0] CMD_RCI  = 3'd7;

    // low two bits of the command select the operation
    localparam logic [1:0] OP_NONE  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_SET   = 2'd2;
    localparam logic [1:0] OP_CLEAR = 2'd3;

    localparam logic [XLEN-1:0] ISA_VALUE = 32'h4000_1100;

    localparam logic [11:0] A_STATUS  = 12'h300;
    localparam logic [11:0] A_ISA     = 12'h301;
    localparam logic [11:0] A_IE      = 12'h304;
    localparam logic [11:0] A_TVEC    = 12'h305;
    localparam logic [11:0] A_SCRATCH = 12'h340;
    localparam logic [11:0] A_EPC     = 12'h341;
    localparam logic [11:0] A_CAUSE   = 12'h342;
    localparam logic [11:0] A_TVAL    = 12'h343;
    localparam logic [11:0] A_IP      = 12'h344;

    localparam int NUM_CSR = 8;
    localparam int CSR_IW  = $clog2(NUM_CSR);

    localparam logic [CSR_IW-1:0] S_STATUS  = 3'd0;
    localparam logic [CSR_IW-1:0] S_IE      = 3'd1;
    localparam logic [CSR_IW-1:0] S_TVEC    = 3'd2;
    localparam logic [CSR_IW-1:0] S_SCRATCH = 3'd3;
    localparam logic [CSR_IW-1:0] S_EPC     = 3'd4;
    localparam logic [CSR_IW-1:0] S_CAUSE   = 3'd5;
    localparam logic [CSR_IW-1:0] S_TVAL    = 3'd6;
    localparam logic [CSR_IW-1:0] S_IP      = 3'd7;

    typedef struct packed {
        logic [2:0]      cmd;
        logic [11:0]     csr_address;
        logic [4:0]      source_index;
        logic [XLEN-1:0] source_value;
        logic [4:0]      dest_index;
    } t_csr_in;

    typedef struct packed {
        logic            dest_write;
        logic [4:0]      dest_number;
        logic [XLEN-1:0] dest_value;
        logic            illegal;
    } t_csr_out;

    // write request from the execute logic to the register store
    typedef struct packed {
        logic            en;
        logic [XLEN-1:0] data;
    } t_csr_wr;

endpackage

@@ sv/csrrf_store.sv @@
// ----------------------------------------------------------------------------
// csrrf_store
// Writable machine CSRs with address decode, read mux and write port.
// ----------------------------------------------------------------------------
module csrrf_store (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [11:0]            i_addr,
    input  csrrf_pkg::t_csr_wr     i_wr,
    output logic [csrrf_pkg::XLEN-1:0] o_rdata
);
    import csrrf_pkg::*;

    logic [XLEN-1:0]   r_csr [NUM_CSR];
    logic              hit;
    logic [CSR_IW-1:0] sel;

    always_comb begin
        hit = 1'b1;
        sel = S_STATUS;
        unique case (i_addr)
            A_STATUS:  sel = S_STATUS;
            A_IE:      sel = S_IE;
            A_TVEC:    sel = S_TVEC;
            A_SCRATCH: sel = S_SCRATCH;
            A_EPC:     sel = S_EPC;
            A_CAUSE:   sel = S_CAUSE;
            A_TVAL:    sel = S_TVAL;
            A_IP:      sel = S_IP;
            default:   hit = 1'b0;
        endcase
    end

    // misa reads as ISA_VALUE; other id registers and unknown addresses read as zero
    always_comb begin
        if (hit) begin
            o_rdata = r_csr[sel];
        end else if (i_addr == A_ISA) begin
            o_rdata = ISA_VALUE;
        end else begin
            o_rdata = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CSR; i++) begin
                r_csr[i] <= '0;
            end
        end else if (i_wr.en && hit) begin
            r_csr[sel] <= i_wr.data;
        end
    end

endmodule

@@ sv/csrrf_exec.sv @@
// ----------------------------------------------------------------------------
// csrrf_exec
// Read-modify-write logic for one CSR instruction.
// ----------------------------------------------------------------------------
module csrrf_exec (
    input  logic                        i_valid,
    input  csrrf_pkg::t_csr_in          i_item,
    input  logic [csrrf_pkg::XLEN-1:0]  i_old,
    output csrrf_pkg::t_csr_wr          o_wr,
    output csrrf_pkg::t_csr_out         o_result
);
    import csrrf_pkg::*;

    logic            illegal;
    logic [XLEN-1:0] operand;

    assign illegal = (i_item.cmd == CMD_ILL0) || (i_item.cmd == CMD_ILL4);

    always_comb begin
        if (i_item.cmd == CMD_RWI || i_item.cmd == CMD_RSI || i_item.cmd == CMD_RCI) begin
            operand = {{(XLEN-5){1'b0}}, i_item.source_index};
        end else begin
            operand = i_item.source_value;
        end
        // set or clear with rs1 zero leaves the csr alone
        if (i_item.source_index == 5'd0 && i_item.cmd[1:0] != OP_WRITE) begin
            operand = '0;
        end
    end

    always_comb begin
        o_wr.en = i_valid && !illegal;
        unique case (i_item.cmd[1:0])
            OP_WRITE: o_wr.data = operand;
            OP_SET:   o_wr.data = i_old | operand;
            OP_CLEAR: o_wr.data = i_old & ~operand;
            OP_NONE:  o_wr.data = i_old;
        endcase
    end

    always_comb begin
        o_result.dest_number = i_item.dest_index;
        o_result.illegal     = illegal;
        o_result.dest_write  = !illegal && (i_item.dest_index != 5'd0);
        o_result.dest_value  = illegal ? '0 : i_old;
    end

endmodule

@@ sv/csr_register_file_rv32_core.sv @@
// ----------------------------------------------------------------------------
// csr_register_file_rv32_core
// RV32 machine CSR file executing one Zicsr instruction per beat.
// ----------------------------------------------------------------------------
// timing: the result strobe is registered through r_in and then r_out
// throughput: one instruction per cycle, busy never rises
// csr update happens in the execute cycle, so back-to-back accesses see it
// reset: synchronous active low, clears all writable csrs and pipeline valids
// results are presented for one cycle; the receiver cannot stall
module csr_register_file_rv32_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  csrrf_pkg::t_csr_in   i_item,
    output logic                 o_done,
    output csrrf_pkg::t_csr_out  o_result
);
    import csrrf_pkg::*;

    logic            r_in_valid;
    t_csr_in         r_in;
    logic            r_out_valid;
    t_csr_out        r_out;
    t_csr_wr         wr;
    t_csr_out        n_out;
    logic [XLEN-1:0] old_val;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= start && !busy;
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_in <= i_item;
        end
        if (r_in_valid) begin
            r_out <= n_out;
        end
    end

    csrrf_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_addr  (r_in.csr_address),
        .i_wr    (wr),
        .o_rdata (old_val)
    );

    csrrf_exec u_exec (
        .i_valid  (r_in_valid),
        .i_item   (r_in),
        .i_old    (old_val),
        .o_wr     (wr),
        .o_result (n_out)
    );

    assign o_done   = r_out_valid;
    assign o_result = r_out;

endmodule

@@ tb/sv/csr_file_tb_pkg.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// csr_file_tb_pkg
// Expected-value tracking for the machine CSR file testbench: a mirror of
// the writable CSRs and a queue of pending instruction results.
// ----------------------------------------------------------------------------
package csr_file_tb_pkg;

    import csrrf_pkg::*;

    // read-only id registers, all read as zero
    localparam logic [11:0] A_VENDOR = 12'hF11;
    localparam logic [11:0] A_ARCH   = 12'hF12;
    localparam logic [11:0] A_IMPL   = 12'hF13;
    localparam logic [11:0] A_HART   = 12'hF14;

    class csr_file_scoreboard;

        logic [XLEN-1:0] csr_bank [NUM_CSR];
        t_csr_out        result_queue [$];
        int              n_instr;
        int              n_checked;
        int              n_errors;
        int              n_illegal;
        int              n_rd_writes;
        int              n_csr_updates;

        function new();
            foreach (csr_bank[i]) csr_bank[i] = '0;
            n_instr       = 0;
            n_checked     = 0;
            n_errors      = 0;
            n_illegal     = 0;
            n_rd_writes   = 0;
            n_csr_updates = 0;
        endfunction

        // bank index of a writable csr, -1 for read-only or unknown
        function int slot_of(logic [11:0] addr);
            case (addr)
                A_STATUS:  return int'(S_STATUS);
                A_IE:      return int'(S_IE);
                A_TVEC:    return int'(S_TVEC);
                A_SCRATCH: return int'(S_SCRATCH);
                A_EPC:     return int'(S_EPC);
                A_CAUSE:   return int'(S_CAUSE);
                A_TVAL:    return int'(S_TVAL);
                A_IP:      return int'(S_IP);
                default:   return -1;
            endcase
        endfunction

        function t_csr_out execute_csr(t_csr_in beat);
            t_csr_out        res;
            logic [XLEN-1:0] operand;
            logic [XLEN-1:0] old_val;
            logic [XLEN-1:0] new_val;
            int              slot;
            res             = '0;
            res.dest_number = beat.dest_index;
            if (beat.cmd == CMD_ILL0 || beat.cmd == CMD_ILL4) begin
                res.illegal = 1'b1;
                return res;
            end
            operand = beat.cmd[2] ? XLEN'(beat.source_index) : beat.source_value;
            // set or clear with rs1 = x0 must not touch the csr
            if (beat.source_index == 5'd0 && beat.cmd[1:0] != OP_WRITE)
                operand = '0;
            slot = slot_of(beat.csr_address);
            if (slot >= 0)
                old_val = csr_bank[slot];
            else if (beat.csr_address == A_ISA)
                old_val = ISA_VALUE;
            else
                old_val = '0;
            case (beat.cmd[1:0])
                OP_WRITE: new_val = operand;
                OP_SET:   new_val = old_val | operand;
                default:  new_val = old_val & ~operand;
            endcase
            if (slot >= 0) begin
                csr_bank[slot] = new_val;
                n_csr_updates++;
            end
            res.dest_write = (beat.dest_index != 5'd0);
            res.dest_value = old_val;
            return res;
        endfunction

        function void note_item(t_csr_in beat);
            t_csr_out res;
            res = execute_csr(beat);
            n_instr++;
            if (res.illegal) n_illegal++;
            if (res.dest_write) n_rd_writes++;
            result_queue.push_back(res);
        endfunction

        function void check_result(t_csr_out got);
            t_csr_out want;
            if (result_queue.size() == 0) begin
                $display("%0t: result with nothing pending, actual %h", $time, got);
                n_errors++;
                return;
            end
            want = result_queue.pop_front();
            n_checked++;
            if (got.dest_write !== want.dest_write) begin
                $display("%0t: dest_write expected %b actual %b",
                         $time, want.dest_write, got.dest_write);
                n_errors++;
            end
            if (got.dest_number !== want.dest_number) begin
                $display("%0t: dest_number expected %0d actual %0d",
                         $time, want.dest_number, got.dest_number);
                n_errors++;
            end
            if (got.dest_value !== want.dest_value) begin
                $display("%0t: dest_value expected %h actual %h",
                         $time, want.dest_value, got.dest_value);
                n_errors++;
            end
            if (got.illegal !== want.illegal) begin
                $display("%0t: illegal expected %b actual %b",
                         $time, want.illegal, got.illegal);
                n_errors++;
            end
        endfunction

        function int pending();
            return result_queue.size();
        endfunction

    endclass

endpackage

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives CSR instructions into the machine CSR file with random idle gaps,
// tracks the expected old values in a mirrored register bank and checks
// every result beat field by field.
// ----------------------------------------------------------------------------
module tb_top;

    import csrrf_pkg::*;
    import csr_file_tb_pkg::*;

    localparam int RANDOM_ITEMS = 1850;
    localparam int CYCLE_LIMIT  = 600000;

    logic     i_clk;
    logic     i_rst_n = 1'b0;
    logic     start   = 1'b0;
    logic     busy;
    t_csr_in  i_item  = '0;
    logic     o_done;
    t_csr_out o_result;

    csr_file_scoreboard sb;
    int cycle_count = 0;
    int burst_left  = 0;

    csr_register_file_rv32_core u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_done   (o_done),
        .o_result (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[csr_register_file_rv32_core] ERROR");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_done)
            sb.check_result(o_result);
    end

    function automatic t_csr_in mk(logic [2:0] cmd, logic [11:0] addr, logic [4:0] idx,
                                   logic [31:0] val, logic [4:0] rd);
        t_csr_in beat;
        beat.cmd          = cmd;
        beat.csr_address  = addr;
        beat.source_index = idx;
        beat.source_value = val;
        beat.dest_index   = rd;
        return beat;
    endfunction

    function automatic logic [11:0] pick_address();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            case ($urandom_range(0, 7))
                0:       return A_STATUS;
                1:       return A_IE;
                2:       return A_TVEC;
                3:       return A_SCRATCH;
                4:       return A_EPC;
                5:       return A_CAUSE;
                6:       return A_TVAL;
                default: return A_IP;
            endcase
        end else if (r < 82) begin
            case ($urandom_range(0, 4))
                0:       return A_ISA;
                1:       return A_VENDOR;
                2:       return A_ARCH;
                3:       return A_IMPL;
                default: return A_HART;
            endcase
        end
        return 12'($urandom_range(0, 4095));
    endfunction

    function automatic logic [2:0] pick_cmd();
        if ($urandom_range(0, 99) < 8)
            return $urandom_range(0, 1) ? CMD_ILL4 : CMD_ILL0;
        case ($urandom_range(0, 5))
            0:       return CMD_RW;
            1:       return CMD_RS;
            2:       return CMD_RC;
            3:       return CMD_RWI;
            4:       return CMD_RSI;
            default: return CMD_RCI;
        endcase
    endfunction

    function automatic t_csr_in random_item();
        t_csr_in beat;
        int      r;
        beat.cmd         = pick_cmd();
        beat.csr_address = pick_address();
        r = $urandom_range(0, 99);
        if (r < 15)      beat.source_index = 5'd0;
        else if (r < 25) beat.source_index = 5'd31;
        else             beat.source_index = 5'($urandom_range(0, 31));
        r = $urandom_range(0, 99);
        if (r < 10)      beat.source_value = '0;
        else if (r < 20) beat.source_value = '1;
        else if (r < 30) beat.source_value = 32'd1 << $urandom_range(0, 31);
        else             beat.source_value = $urandom();
        beat.dest_index = ($urandom_range(0, 99) < 15) ? 5'd0 : 5'($urandom_range(0, 31));
        return beat;
    endfunction

    // returns at the edge that accepts the beat
    task automatic send_item(input t_csr_in beat);
        i_item <= beat;
        start  <= 1'b1;
        do @(posedge i_clk); while (busy);
        sb.note_item(beat);
    endtask

    task automatic idle_gap();
        int gap;
        int r;
        if (burst_left > 0) begin
            burst_left--;
            gap = 0;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 3) begin
                burst_left = $urandom_range(20, 60);
                gap = 0;
            end else if (r < 50) gap = 0;
            else if (r < 85)     gap = $urandom_range(1, 3);
            else if (r < 97)     gap = $urandom_range(4, 10);
            else                 gap = $urandom_range(20, 60);
        end
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic issue(input t_csr_in beat);
        send_item(beat);
        idle_gap();
    endtask

    initial begin
        sb = new();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // rs1 = x0 on a register write still writes the delivered value
        issue(mk(CMD_RW,   A_SCRATCH, 5'd0,  32'hFFFF_FFFF, 5'd31));
        issue(mk(CMD_RS,   A_SCRATCH, 5'd0,  32'hFFFF_FFFF, 5'd5));
        issue(mk(CMD_RC,   A_SCRATCH, 5'd0,  32'hFFFF_FFFF, 5'd0));
        issue(mk(CMD_RC,   A_SCRATCH, 5'd31, 32'h0F0F_0F0F, 5'd1));
        issue(mk(CMD_RS,   A_SCRATCH, 5'd7,  32'h0000_0001, 5'd2));
        issue(mk(CMD_RWI,  A_STATUS,  5'd31, 32'hFFFF_FFFF, 5'd3));
        issue(mk(CMD_RSI,  A_STATUS,  5'd0,  32'h0000_0000, 5'd4));
        issue(mk(CMD_RCI,  A_STATUS,  5'd1,  32'h0000_0000, 5'd6));
        issue(mk(CMD_RSI,  A_STATUS,  5'd16, 32'h0000_0000, 5'd7));
        issue(mk(CMD_ILL0, A_STATUS,  5'd31, 32'hFFFF_FFFF, 5'd31));
        issue(mk(CMD_ILL4, A_SCRATCH, 5'd31, 32'hFFFF_FFFF, 5'd8));
        // read-only and unknown addresses ignore the write; the other writable csrs are written too
        issue(mk(CMD_RW,   A_ISA,     5'd9,  32'hFFFF_FFFF, 5'd9));
        issue(mk(CMD_RS,   A_ISA,     5'd10, 32'hFFFF_FFFF, 5'd10));
        issue(mk(CMD_RW,   A_VENDOR,  5'd11, 32'hFFFF_FFFF, 5'd11));
        issue(mk(CMD_RC,   A_HART,    5'd12, 32'hFFFF_FFFF, 5'd12));
        issue(mk(CMD_RWI,  12'hFFF,   5'd31, 32'h0000_0000, 5'd13));
        issue(mk(CMD_RW,   12'h000,   5'd13, 32'hFFFF_FFFF, 5'd14));
        issue(mk(CMD_RW,   A_IE,      5'd14, 32'hFFFF_FFFF, 5'd15));
        issue(mk(CMD_RW,   A_TVEC,    5'd15, 32'h8000_0001, 5'd16));
        issue(mk(CMD_RW,   A_EPC,     5'd16, 32'hDEAD_BEEF, 5'd17));
        issue(mk(CMD_RW,   A_CAUSE,   5'd17, 32'h8000_000B, 5'd18));
        issue(mk(CMD_RW,   A_TVAL,    5'd18, 32'hFFFF_FFFF, 5'd19));
        issue(mk(CMD_RW,   A_IP,      5'd19, 32'h0000_0888, 5'd20));
        issue(mk(CMD_RCI,  A_IP,      5'd31, 32'h0000_0000, 5'd0));
        issue(mk(CMD_RC,   A_IE,      5'd20, 32'hFFFF_FFFF, 5'd21));

        for (int n = 0; n < RANDOM_ITEMS; n++)
            issue(random_item());
        start <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (sb.pending() != 0) begin
            $display("%0t: %0d results never arrived", $time, sb.pending());
            sb.n_errors += sb.pending();
        end
        $display("%0d CSR instructions checked: %0d illegal, %0d with an rd write,",
                 sb.n_checked, sb.n_illegal, sb.n_rd_writes);
        $display("%0d writable CSR updates, %0d field mismatches",
                 sb.n_csr_updates, sb.n_errors);
        if (sb.n_errors == 0)
            $display("[csr_register_file_rv32_core] OK");
        else
            $display("[csr_register_file_rv32_core] ERROR");
        $finish;
    end

endmodule

@@ csr_register_file_rv32_core.f @@
sv/csrrf_pkg.sv
sv/csrrf_store.sv
sv/csrrf_exec.sv
sv/csr_register_file_rv32_core.sv
tb/sv/csr_file_tb_pkg.sv
tb/sv/tb_top.sv
